// File: rtl/mmcs_pkg.sv
package mmcs_pkg;

	localparam int PIX_W = 8;
	localparam int NUM_W = 2 * PIX_W;
	localparam int STEP_W = $clog2(PIX_W);
	localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};
	localparam logic [PIX_W-1:0] PIX_MIN = '0;

	localparam logic REQ_MEASURE = 1'b0;
	localparam logic REQ_APPLY = 1'b1;

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		logic flat;
		logic [NUM_W-1:0] num;
		pix_t range;
	} div_req_t;

	typedef struct packed {
		logic idle;
		logic done;
	} div_stat_t;

endpackage

// File: rtl/min_max_contrast_stretch.sv
// channel  dir  tdata           tuser
// s_       in   [7:0] pixel_in  [0] req_type, [1] first_pixel
// m_       out  [7:0] pixel_out -
// a measure transaction updates the running range and gives no output
// an apply transaction is loaded into the divider, which forms eight quotient
// bits by restoring division, then is handed over to the output register
// one item at a time; a full output register holds the divider until taken
// arst_n clears the running range to min 255, max 0
module min_max_contrast_stretch
	import mmcs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] pixel_in
	input  logic [1:0] s_tuser,  // [0] req_type, [1] first_pixel
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata   // [7:0] pixel_out
);

	pix_t min_seen;
	pix_t max_seen;
	pix_t pix;
	pix_t clamped;
	pix_t delta;
	logic s_fire;
	logic measure;
	logic apply;
	logic take;
	div_req_t req;
	div_stat_t stat;
	pix_t quot;
	logic out_valid_q;
	pix_t out_data_q;

	assign pix = s_tdata;
	assign s_fire = s_tvalid && s_tready;
	assign measure = s_fire && s_tuser[0] == REQ_MEASURE;
	assign apply = s_fire && s_tuser[0] == REQ_APPLY;
	assign s_tready = stat.idle;

	mmcs_track u_track (
		.clk(clk),
		.arst_n(arst_n),
		.upd(measure),
		.first(s_tuser[1]),
		.pixel(pix),
		.min_seen(min_seen),
		.max_seen(max_seen)
	);

	always_comb begin
		if (pix < min_seen) begin
			clamped = min_seen;
		end else if (pix > max_seen) begin
			clamped = max_seen;
		end else begin
			clamped = pix;
		end
	end

	// times 255 as times 256 minus one
	assign delta = clamped - min_seen;
	assign req.flat = max_seen <= min_seen;
	assign req.num = {delta, PIX_MIN} - {PIX_MIN, delta};
	assign req.range = max_seen - min_seen;

	mmcs_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(apply),
		.req(req),
		.take(take),
		.stat(stat),
		.quot(quot)
	);

	assign take = stat.done && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_data_q <= quot;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

	a_apply_busy: assert property (@(posedge clk) disable iff (!arst_n)
		apply |=> !s_tready)
		else $error("divider not busy after apply");

	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		measure |=> min_seen <= max_seen)
		else $error("min above max after measure");

	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done && !take |=> stat.done && $stable(quot))
		else $error("divider result lost while output full");

endmodule

// File: rtl/mmcs_track.sv
module mmcs_track
	import mmcs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic upd,
	input  logic first,
	input  pix_t pixel,
	output pix_t min_seen,
	output pix_t max_seen
);

	pix_t min_q;
	pix_t max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= PIX_MAX;
			max_q <= PIX_MIN;
		end else if (upd) begin
			if (first) begin
				min_q <= pixel;
				max_q <= pixel;
			end else begin
				if (pixel < min_q) begin
					min_q <= pixel;
				end
				if (pixel > max_q) begin
					max_q <= pixel;
				end
			end
		end
	end

	assign min_seen = min_q;
	assign max_seen = max_q;

endmodule

// File: rtl/mmcs_div.sv
module mmcs_div
	import mmcs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  div_req_t  req,
	input  logic      take,
	output div_stat_t stat,
	output pix_t      quot
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0] state_q;
	logic [STEP_W-1:0] cnt_q;
	pix_t rem_q;
	pix_t lo_q;
	pix_t div_q;
	logic flat_q;

	logic [PIX_W:0] trial;
	logic [PIX_W:0] diff;
	logic fits;

	// one quotient bit per cycle, low dividend bits and quotient share the shift register
	assign trial = {rem_q, lo_q[PIX_W-1]};
	assign fits = trial >= {1'b0, div_q};
	assign diff = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RUN;
						cnt_q <= '0;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == STEP_W'(PIX_W - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			rem_q <= req.num[NUM_W-1:PIX_W];
			lo_q <= req.num[PIX_W-1:0];
			div_q <= req.range;
			flat_q <= req.flat;
		end else if (state_q == ST_RUN) begin
			rem_q <= fits ? diff[PIX_W-1:0] : trial[PIX_W-1:0];
			lo_q <= {lo_q[PIX_W-2:0], fits};
		end
	end

	assign stat.idle = state_q == ST_IDLE;
	assign stat.done = state_q == ST_DONE;
	assign quot = flat_q ? PIX_MIN : lo_q;

endmodule

// File: sim/stretch_check.sv
module stretch_check
	import mmcs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] pixel_in
	input  logic [1:0] s_tuser,  // [0] req_type, [1] first_pixel
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,  // [7:0] pixel_out
	output int         errors,
	output int         waiting
);

	pix_t lo_seen;
	pix_t hi_seen;
	pix_t want;
	pix_t expected_pixels[$];

	function automatic pix_t stretch_value(pix_t p, pix_t lo, pix_t hi);
		logic [NUM_W-1:0] num;
		logic [NUM_W-1:0] span;
		pix_t c;
		if (hi <= lo) begin
			return PIX_MIN;
		end
		c = (p < lo) ? lo : ((p > hi) ? hi : p);
		num = NUM_W'(c - lo) * NUM_W'(PIX_MAX);
		span = NUM_W'(hi - lo);
		return pix_t'(num / span);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_seen = PIX_MAX;
			hi_seen = PIX_MIN;
			expected_pixels.delete();
			errors = 0;
			waiting = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_pixels.size() == 0) begin
					$display("%0t: pixel_out expected none, actual %0d", $time, m_tdata);
					errors++;
				end else begin
					want = expected_pixels.pop_front();
					if (m_tdata !== want) begin
						$display("%0t: pixel_out expected %0d, actual %0d",
							$time, want, m_tdata);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser[0] == REQ_MEASURE) begin
					if (s_tuser[1]) begin
						lo_seen = s_tdata;
						hi_seen = s_tdata;
					end else begin
						if (s_tdata < lo_seen) lo_seen = s_tdata;
						if (s_tdata > hi_seen) hi_seen = s_tdata;
					end
				end else begin
					expected_pixels.push_back(stretch_value(s_tdata, lo_seen, hi_seen));
				end
			end
			waiting = expected_pixels.size();
		end
	end

endmodule

// File: sim/min_max_contrast_stretch_tb.sv
module min_max_contrast_stretch_tb;
	import mmcs_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = '0;   // [7:0] pixel_in
	logic [1:0] s_tuser = '0;   // [0] req_type, [1] first_pixel
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;        // [7:0] pixel_out
	int         errors;
	int         waiting;
	int         items_sent = 0;
	bit         idle_on = 1'b1;

	min_max_contrast_stretch u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	stretch_check u_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.errors  (errors),
		.waiting (waiting)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_tready <= !(idle_on && $urandom_range(99) < 7);
	end

	// called at a falling edge, returns at the falling edge after the transaction
	task automatic send_pixel(input logic kind, input pix_t pix, input logic first);
		while (idle_on && $urandom_range(99) < 7) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pix;
		s_tuser <= {first, kind};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (waiting != 0) @(negedge clk);
	endtask

	// measure pass over a random band, then an apply pass, or one frame in ten of noise
	task automatic run_frame();
		int   n_meas;
		int   n_apply;
		pix_t band_lo;
		pix_t band_hi;
		pix_t p;
		n_meas = $urandom_range(1, 12);
		n_apply = $urandom_range(1, 12);
		band_lo = pix_t'($urandom_range(0, 255));
		band_hi = ($urandom_range(9) == 0) ? band_lo
			: pix_t'($urandom_range(band_lo, 255));
		if ($urandom_range(9) == 0) begin
			// noise: unrelated items of any kind
			repeat (n_meas + n_apply) begin
				send_pixel(1'($urandom_range(1)), pix_t'($urandom_range(255)),
					1'($urandom_range(1)));
			end
			return;
		end
		for (int i = 0; i < n_meas; i++) begin
			p = pix_t'($urandom_range(band_lo, band_hi));
			send_pixel(REQ_MEASURE, p, (i == 0) ? ($urandom_range(9) != 0) : 1'b0);
		end
		repeat (n_apply) begin
			p = ($urandom_range(9) < 7) ? pix_t'($urandom_range(band_lo, band_hi))
				: pix_t'($urandom_range(255));
			send_pixel(REQ_APPLY, p, 1'($urandom_range(1)));
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// apply before any measure
		send_pixel(REQ_APPLY, 8'd0, 1'b0);
		send_pixel(REQ_APPLY, 8'd255, 1'b1);
		// measure with no first pixel runs on from the reset range
		send_pixel(REQ_MEASURE, 8'd100, 1'b0);
		send_pixel(REQ_APPLY, 8'd100, 1'b0);
		// full range
		send_pixel(REQ_MEASURE, 8'd0, 1'b1);
		send_pixel(REQ_MEASURE, 8'd255, 1'b0);
		send_pixel(REQ_APPLY, 8'd0, 1'b0);
		send_pixel(REQ_APPLY, 8'd255, 1'b0);
		send_pixel(REQ_APPLY, 8'd128, 1'b0);
		send_pixel(REQ_APPLY, 8'd77, 1'b1);
		// range of one, with clamping on both sides
		send_pixel(REQ_MEASURE, 8'd51, 1'b1);
		send_pixel(REQ_MEASURE, 8'd50, 1'b0);
		send_pixel(REQ_APPLY, 8'd49, 1'b0);
		send_pixel(REQ_APPLY, 8'd50, 1'b0);
		send_pixel(REQ_APPLY, 8'd51, 1'b0);
		send_pixel(REQ_APPLY, 8'd200, 1'b0);
		// flat channel
		send_pixel(REQ_MEASURE, 8'd200, 1'b1);
		send_pixel(REQ_MEASURE, 8'd200, 1'b0);
		send_pixel(REQ_APPLY, 8'd200, 1'b0);
		send_pixel(REQ_APPLY, 8'd10, 1'b0);
		// first pixel restarts after a flat channel
		send_pixel(REQ_MEASURE, 8'd255, 1'b1);
		send_pixel(REQ_MEASURE, 8'd170, 1'b0);
		send_pixel(REQ_APPLY, 8'd85, 1'b0);
		send_pixel(REQ_APPLY, 8'd213, 1'b0);
		drain_results();

		while (items_sent < 1840) begin
			idle_on = !(items_sent > 800 && items_sent < 1150);
			run_frame();
			if ($urandom_range(39) == 0) drain_results();
		end

		drain_results();
		repeat (20) @(negedge clk);
		if (errors == 0 && waiting == 0) begin
			$display("min_max_contrast_stretch_tb: clean");
		end else begin
			$display("min_max_contrast_stretch_tb: errors");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("min_max_contrast_stretch_tb: errors");
		$finish;
	end

endmodule

// File: min_max_contrast_stretch.f
rtl/mmcs_pkg.sv
rtl/mmcs_track.sv
rtl/mmcs_div.sv
rtl/min_max_contrast_stretch.sv
sim/stretch_check.sv
sim/min_max_contrast_stretch_tb.sv
